### design/efr_pkg.sv
// Shared types and constants of the explicit fragment reassembler.
`default_nettype none

package efr_pkg;

  localparam int STORE_BYTES = 32;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int FILL_W      = 6;

  localparam logic [7:0] FRAG_FLAG = 8'h80;
  localparam logic [7:0] TYPE_SET  = 8'hC0;
  localparam logic [7:0] HDR_KEEP  = 8'h7F;
  localparam logic [3:0] MAX_LEN   = 4'd8;
  localparam logic [3:0] HDR_LEN   = 4'd2;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_PASS  = 2'd2,
    KIND_ACKRX = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FT_FIRST  = 2'd0,
    FT_MIDDLE = 2'd1,
    FT_LAST   = 2'd2,
    FT_ACK    = 2'd3
  } ftype_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RESULT,
    ST_READ,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [47:0] payload;
    logic [3:0]  frame_length;
  } in_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  ack_byte_zero;
    logic [7:0]  ack_byte_one;
    logic        ack_code;
    logic [7:0]  peer_status;
    logic [7:0]  message_byte;
    logic [5:0]  byte_position;
    logic [5:0]  message_size;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } store_req_t;

endpackage

`default_nettype wire

### design/efr_store.sv
// Assembly byte store: one write port, one registered read port.
`default_nettype none

module efr_store (
  input  wire logic                clk_i,
  input  wire efr_pkg::store_req_t req_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [efr_pkg::STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/explicit_fragment_reassembler.sv
// Explicit-message fragment reassembler, receive side.
// A single-result frame goes through the result state to the output register; a stored
// fragment writes its n bytes (up to 7) one per cycle, then shows its ack the same way.
// No new frame is taken until the block is idle again; a finished message streams each
// byte by a store read, then a send, which waits while the output is stalled.
// Reset clears progress and sets the limit to 32; the store itself is not cleared.
`default_nettype none

module explicit_fragment_reassembler (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire efr_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output efr_pkg::out_word_t      out_word_o,
  input  wire logic               cfg_we_i,
  input  wire logic [5:0]         cfg_wdata_i
);

  localparam logic [efr_pkg::FILL_W-1:0] STORE_LIMIT = efr_pkg::FILL_W'(efr_pkg::STORE_BYTES);

  efr_pkg::state_e    state_q, state_d;
  logic [5:0]         limit_q;
  logic [5:0]         fill_q, fill_d;
  logic [5:0]         exp_q, exp_d;
  logic [55:0]        wbuf_q, wbuf_d;
  logic [2:0]         wcnt_q, wcnt_d;
  logic [5:0]         wpos_q, wpos_d;
  efr_pkg::out_word_t res_q, res_d;
  logic               stream_q, stream_d;
  logic [5:0]         size_q, size_d;
  logic [5:0]         rptr_q, rptr_d;
  efr_pkg::out_word_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  efr_pkg::store_req_t req;
  logic [7:0]          rdata;

  logic                accept;
  logic                out_free;
  logic [3:0]          len;
  logic [2:0]          nd;
  efr_pkg::ftype_e     ftype;
  logic [5:0]          count;
  logic [5:0]          limit_use;
  logic [5:0]          start;
  logic [6:0]          newfill;
  logic                over;
  efr_pkg::out_word_t  ack_w;

  efr_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign len       = (in_word_i.frame_length > efr_pkg::MAX_LEN) ? efr_pkg::MAX_LEN
                                                                 : in_word_i.frame_length;
  assign nd        = (len > efr_pkg::HDR_LEN) ? 3'(len - efr_pkg::HDR_LEN) : 3'd0;
  assign ftype     = efr_pkg::ftype_e'(in_word_i.header_second[7:6]);
  assign count     = in_word_i.header_second[5:0];
  assign limit_use = (limit_q < STORE_LIMIT) ? limit_q : STORE_LIMIT;
  assign start     = (ftype == efr_pkg::FT_FIRST) ? 6'd1 : fill_q;
  assign newfill   = {1'b0, start} + {4'b0, nd};
  assign over      = newfill > {1'b0, limit_use};

  always_comb begin
    ack_w               = '0;
    ack_w.kind          = efr_pkg::KIND_ACK;
    ack_w.ack_byte_zero = in_word_i.header_first | efr_pkg::FRAG_FLAG;
    ack_w.ack_byte_one  = in_word_i.header_second | efr_pkg::TYPE_SET;
    ack_w.last          = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= efr_pkg::ST_IDLE;
      limit_q     <= 6'd32;
      fill_q      <= '0;
      exp_q       <= '0;
      stream_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      exp_q       <= exp_d;
      stream_q    <= stream_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
    wcnt_q <= wcnt_d;
    wpos_q <= wpos_d;
    res_q  <= res_d;
    size_q <= size_d;
    rptr_q <= rptr_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    exp_d       = exp_q;
    wbuf_d      = wbuf_q;
    wcnt_d      = wcnt_q;
    wpos_d      = wpos_q;
    res_d       = res_q;
    stream_d    = stream_q;
    size_d      = size_q;
    rptr_d      = rptr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != efr_pkg::ST_IDLE);
    req         = '0;

    unique case (state_q)
      efr_pkg::ST_IDLE: begin
        stream_d = 1'b0;
        if (accept) begin
          res_d = ack_w;
          if (!in_word_i.header_first[7]) begin
            fill_d     = '0;
            exp_d      = '0;
            res_d      = '0;
            res_d.kind = efr_pkg::KIND_PASS;
            res_d.last = 1'b1;
            state_d    = efr_pkg::ST_RESULT;
          end else if (ftype == efr_pkg::FT_ACK) begin
            res_d             = '0;
            res_d.kind        = efr_pkg::KIND_ACKRX;
            res_d.peer_status = in_word_i.payload[7:0];
            res_d.last        = 1'b1;
            state_d           = efr_pkg::ST_RESULT;
          end else if (ftype == efr_pkg::FT_FIRST && count != 6'd0) begin
            fill_d = '0;
            exp_d  = '0;
          end else if (ftype != efr_pkg::FT_FIRST && exp_q == 6'd0) begin
            state_d = efr_pkg::ST_IDLE;
          end else if (ftype == efr_pkg::FT_MIDDLE && count == 6'(exp_q - 6'd1)) begin
            state_d = efr_pkg::ST_RESULT;
          end else if (ftype != efr_pkg::FT_FIRST && count != exp_q) begin
            fill_d = '0;
            exp_d  = '0;
          end else if (over) begin
            fill_d         = '0;
            exp_d          = '0;
            res_d.ack_code = 1'b1;
            state_d        = efr_pkg::ST_RESULT;
          end else begin
            // accepted fragment: queue its bytes for the store
            if (ftype == efr_pkg::FT_FIRST) begin
              wbuf_d = {in_word_i.payload, in_word_i.header_first & efr_pkg::HDR_KEEP};
              wcnt_d = nd + 3'd1;
              wpos_d = '0;
            end else begin
              wbuf_d = {8'h00, in_word_i.payload};
              wcnt_d = nd;
              wpos_d = fill_q;
            end
            if (ftype == efr_pkg::FT_LAST) begin
              fill_d     = '0;
              exp_d      = '0;
              size_d     = newfill[5:0];
              rptr_d     = '0;
              stream_d   = (newfill != 7'd0);
              res_d.last = (newfill == 7'd0);
            end else begin
              fill_d = newfill[5:0];
              exp_d  = (ftype == efr_pkg::FT_FIRST) ? 6'd1 : 6'(exp_q + 6'd1);
            end
            state_d = efr_pkg::ST_WRITE;
          end
        end
      end
      efr_pkg::ST_WRITE: begin
        if (wcnt_q != 3'd0) begin
          req.we    = 1'b1;
          req.waddr = wpos_q[efr_pkg::STORE_AW-1:0];
          req.wdata = wbuf_q[7:0];
          wbuf_d    = wbuf_q >> 8;
          wcnt_d    = wcnt_q - 3'd1;
          wpos_d    = wpos_q + 6'd1;
        end else begin
          state_d = efr_pkg::ST_RESULT;
        end
      end
      efr_pkg::ST_RESULT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = stream_q ? efr_pkg::ST_READ : efr_pkg::ST_IDLE;
        end
      end
      efr_pkg::ST_READ: begin
        req.re    = 1'b1;
        req.raddr = rptr_q[efr_pkg::STORE_AW-1:0];
        state_d   = efr_pkg::ST_SEND;
      end
      efr_pkg::ST_SEND: begin
        if (out_free) begin
          out_d               = '0;
          out_d.kind          = efr_pkg::KIND_BYTE;
          out_d.message_byte  = rdata;
          out_d.byte_position = rptr_q;
          out_d.message_size  = size_q;
          out_d.last          = (6'(rptr_q + 6'd1) == size_q);
          out_valid_d         = 1'b1;
          rptr_d              = rptr_q + 6'd1;
          state_d             = out_d.last ? efr_pkg::ST_IDLE : efr_pkg::ST_READ;
        end
      end
      default: begin
        state_d = efr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= STORE_LIMIT)
    else $error("fill count beyond store");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (wpos_q < STORE_LIMIT) && (state_q == efr_pkg::ST_WRITE))
    else $error("store write out of range");

  a_stream_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == efr_pkg::ST_SEND) |-> (rptr_q < size_q))
    else $error("stream position past message size");

  a_read_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == efr_pkg::ST_READ) |=> (state_q == efr_pkg::ST_SEND))
    else $error("store read not followed by send");

  a_byte_from_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)
      && out_q.kind == efr_pkg::KIND_BYTE) |-> ($past(state_q) == efr_pkg::ST_SEND))
    else $error("message byte issued outside stream");
`endif

endmodule

`default_nettype wire

### test/efr_checker.sv
`timescale 1ns / 1ps
// Watches both channels of the fragment reassembler, predicts each result word and compares.
module efr_checker import efr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_word_t  in_word_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_word_t out_word_i,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam logic ACK_OK    = 1'b0;
  localparam logic ACK_LIMIT = 1'b1;

  logic [7:0] msg_store [STORE_BYTES];
  logic [5:0] fill;
  logic [5:0] next_frag;
  logic [5:0] size_limit;
  out_word_t  due_words [$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic out_word_t ack_word(input logic [7:0] a0, input logic [7:0] a1,
                                         input logic code, input logic last);
    out_word_t r;
    r = '0;
    r.kind          = KIND_ACK;
    r.ack_byte_zero = a0;
    r.ack_byte_one  = a1;
    r.ack_code      = code;
    r.last          = last;
    return r;
  endfunction

  function automatic int store_data(input int start, input logic [47:0] pl, input int nd);
    int p;
    for (int i = 0; i < nd; i++) begin
      p = start + i;
      if (p < STORE_BYTES) msg_store[p[STORE_AW-1:0]] = pl[8*i +: 8];
    end
    return start + nd;
  endfunction

  task automatic drop_progress();
    fill      = '0;
    next_frag = '0;
  endtask

  task automatic reassemble_frame(input in_word_t w);
    logic [3:0] len;
    int         nd;
    int         lim;
    int         newfill;
    ftype_e     ft;
    logic [5:0] cnt;
    logic [7:0] a0;
    logic [7:0] a1;
    out_word_t  r;
    len = (w.frame_length > MAX_LEN) ? MAX_LEN : w.frame_length;
    nd  = (len > HDR_LEN) ? int'(len - HDR_LEN) : 0;
    a0  = w.header_first | FRAG_FLAG;
    a1  = w.header_second | TYPE_SET;
    ft  = ftype_e'(w.header_second[7:6]);
    cnt = w.header_second[5:0];
    r   = '0;
    if (!w.header_first[7]) begin
      drop_progress();
      r.kind = KIND_PASS;
      r.last = 1'b1;
      due_words.push_back(r);
      return;
    end
    if (ft == FT_ACK) begin
      r.kind        = KIND_ACKRX;
      r.peer_status = w.payload[7:0];
      r.last        = 1'b1;
      due_words.push_back(r);
      return;
    end
    if (ft == FT_FIRST) begin
      drop_progress();
      if (cnt != 6'd0) return;
      msg_store[0] = w.header_first & HDR_KEEP;
      newfill = store_data(1, w.payload, nd);
    end else begin
      if (next_frag == 6'd0) return;
      // repeated middle fragment: ack again, state untouched
      if (ft == FT_MIDDLE && cnt == next_frag - 6'd1) begin
        due_words.push_back(ack_word(a0, a1, ACK_OK, 1'b1));
        return;
      end
      if (cnt != next_frag) begin
        drop_progress();
        return;
      end
      newfill = store_data(int'(fill), w.payload, nd);
    end
    lim = (int'(size_limit) < STORE_BYTES) ? int'(size_limit) : STORE_BYTES;
    if (newfill > lim) begin
      drop_progress();
      due_words.push_back(ack_word(a0, a1, ACK_LIMIT, 1'b1));
      return;
    end
    fill = 6'(newfill);
    if (ft != FT_LAST) begin
      next_frag = next_frag + 6'd1;
      due_words.push_back(ack_word(a0, a1, ACK_OK, 1'b1));
      return;
    end
    due_words.push_back(ack_word(a0, a1, ACK_OK, fill == 6'd0));
    for (int i = 0; i < int'(fill); i++) begin
      r = '0;
      r.kind          = KIND_BYTE;
      r.message_byte  = msg_store[i[STORE_AW-1:0]];
      r.byte_position = 6'(i);
      r.message_size  = fill;
      r.last          = (i + 1 == int'(fill));
      due_words.push_back(r);
    end
    drop_progress();
  endtask

  function automatic int field_diff(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (due_words.size() == 0) begin
      $error("unexpected word: kind %0d", got.kind);
      mismatches++;
      return;
    end
    want = due_words.pop_front();
    mismatches += field_diff("kind", 8'(want.kind), 8'(got.kind))
                + field_diff("ack_byte_zero", want.ack_byte_zero, got.ack_byte_zero)
                + field_diff("ack_byte_one", want.ack_byte_one, got.ack_byte_one)
                + field_diff("ack_code", 8'(want.ack_code), 8'(got.ack_code))
                + field_diff("peer_status", want.peer_status, got.peer_status)
                + field_diff("message_byte", want.message_byte, got.message_byte)
                + field_diff("byte_position", 8'(want.byte_position), 8'(got.byte_position))
                + field_diff("message_size", 8'(want.message_size), 8'(got.message_size))
                + field_diff("last", 8'(want.last), 8'(got.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (msg_store[i]) msg_store[i] = '0;
      drop_progress();
      size_limit = 6'd32;
      due_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) size_limit = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) check_word(out_word_i);
      if (in_valid_i && !in_stall_i) reassemble_frame(in_word_i);
      pending_o <= due_words.size();
    end
  end

endmodule

### test/explicit_fragment_reassembler_test.sv
`timescale 1ns / 1ps
// Testbench top for the fragment reassembler: frame stimulus, idling phases and verdict.
module explicit_fragment_reassembler_test;
  import efr_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_word_t   in_word   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_we    = 1'b0;
  logic [5:0] cfg_wdata = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent           = 0;
  int quiet_cycles   = 0;
  int fail_count;
  int pending;

  explicit_fragment_reassembler uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  efr_checker frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("explicit_fragment_reassembler_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [47:0] rand_payload();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [3:0] rand_len();
    if ($urandom_range(9) == 0) return 4'($urandom_range(15));
    return 4'($urandom_range(8, 2));
  endfunction

  function automatic in_word_t make_frame(input logic [7:0] h0, input logic [7:0] h1,
                                          input logic [3:0] len, input logic [47:0] pl);
    in_word_t w;
    w.header_first  = h0;
    w.header_second = h1;
    w.payload       = pl;
    w.frame_length  = len;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // first, middles, last, with occasional repeats, bad counts, foreign words and aborts
  task automatic random_chain();
    logic [7:0] h0;
    int         mids;
    int         d;
    ftype_e     ft;
    h0   = {1'b1, 7'($urandom)};
    mids = $urandom_range(4);
    send_word(make_frame(h0, {FT_FIRST, 6'd0}, rand_len(), rand_payload()));
    for (int k = 1; k <= mids + 1; k++) begin
      d = $urandom_range(99);
      if (d < 8)
        send_word(make_frame(h0, {FT_MIDDLE, 6'(k - 1)}, rand_len(), rand_payload()));
      else if (d < 12)
        send_word(make_frame(h0, {2'($urandom), 6'($urandom)}, rand_len(), rand_payload()));
      else if (d < 16)
        send_word(make_frame(8'($urandom), {FT_ACK, 6'($urandom)}, rand_len(),
                             rand_payload()));
      else if (d < 19)
        return;
      ft = (k > mids) ? FT_LAST : FT_MIDDLE;
      send_word(make_frame(h0, {ft, 6'(k)}, rand_len(), rand_payload()));
    end
  endtask

  task automatic run_phase(input logic [5:0] lim, input int idle, input int stall,
                           input int words);
    int goal;
    wait_drain();
    cfg_wdata <= lim;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    goal = sent + words;
    while (sent < goal) begin
      if ($urandom_range(99) < 75)
        random_chain();
      else
        send_word(make_frame(8'($urandom), 8'($urandom), 4'($urandom), rand_payload()));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset limit
    send_word(make_frame(8'h00, 8'h00, 4'd0, '0));
    send_word(make_frame(8'h7F, 8'hFF, 4'd15, '1));
    send_word(make_frame(8'hFF, 8'hFF, 4'd0, rand_payload()));
    send_word(make_frame(8'hC1, {FT_LAST, 6'd1}, 4'd8, rand_payload()));
    send_word(make_frame(8'hC1, {FT_FIRST, 6'd63}, 4'd8, rand_payload()));
    send_word(make_frame(8'hA5, {FT_FIRST, 6'd0}, 4'd8, rand_payload()));
    send_word(make_frame(8'hA5, {FT_MIDDLE, 6'd1}, 4'd15, rand_payload()));
    send_word(make_frame(8'hA5, {FT_MIDDLE, 6'd1}, 4'd8, rand_payload()));
    send_word(make_frame(8'hA5, {FT_MIDDLE, 6'd3}, 4'd8, rand_payload()));
    send_word(make_frame(8'h80, {FT_FIRST, 6'd0}, 4'd1, rand_payload()));
    send_word(make_frame(8'h80, {FT_LAST, 6'd1}, 4'd0, rand_payload()));
    // exactly at the limit, then one fragment past it
    for (int over = 0; over < 2; over++) begin
      send_word(make_frame(8'hFF, {FT_FIRST, 6'd0}, 4'd8, rand_payload()));
      for (int m = 1; m <= 4; m++)
        send_word(make_frame(8'hFF, {FT_MIDDLE, 6'(m)}, 4'd8, rand_payload()));
      if (over == 0)
        send_word(make_frame(8'hFF, {FT_LAST, 6'd5}, 4'd3, rand_payload()));
      else
        send_word(make_frame(8'hFF, {FT_MIDDLE, 6'd5}, 4'd8, rand_payload()));
    end

    run_phase(6'd62, 0, 0, 6);
    // fragment count runs through all 64 values and wraps to zero
    send_word(make_frame(8'h9C, {FT_FIRST, 6'd0}, 4'd1, rand_payload()));
    for (int m = 1; m < 64; m++)
      send_word(make_frame(8'h9C, {FT_MIDDLE, 6'(m)}, 4'd0, rand_payload()));
    send_word(make_frame(8'h9C, {FT_LAST, 6'd0}, 4'd8, rand_payload()));

    run_phase(6'd20, 87, 0, 6);
    run_phase(6'd0, 0, 87, 2);
    run_phase(6'd32, 0, 87, 6);
    run_phase(6'd9, 8, 8, 6);
    wait_drain();

    if (fail_count == 0)
      $display("explicit_fragment_reassembler_test: PASS");
    else
      $display("explicit_fragment_reassembler_test: FAIL");
    $finish;
  end

endmodule
